### rtl/spee_pkg.sv
// Shared types and constants for the stack positional edit engine.
// No dependencies; used by all rtl files but spee_prefix_or.
package spee_pkg;

    localparam int FUNC_W    = 3;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 7;
    localparam int HELD_W    = 7;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 56;   // 49 payload bits padded to bytes
    localparam int M_TDATA_W = 16;   // 10 payload bits padded to bytes

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_DELETE = 3'd1,
        FN_SWAP   = 3'd2,
        FN_SEARCH = 3'd3,
        FN_COUNT  = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_APPLY
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_SWAP
    } cell_op_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic     calc;   // register key compare this cycle
        cell_op_t op;     // update applied at this edge
    } cell_ctrl_t;

    // Per-cell position flags.
    typedef struct packed {
        logic occ;        // cell lies below the fill count
        logic sel_a;      // cell is position A
        logic after_a;    // cell lies deeper than position A
        logic sel_b;      // cell is position B
        logic shift;      // a delete hit sits at or above this cell
    } cell_flags_t;

endpackage

### rtl/spee_prefix_or.sv
// Log-depth prefix OR, bit 0 first.
// Depends on nothing; used by the top level for the delete and insert shift masks.
module spee_prefix_or #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] bits,
    output logic [WIDTH-1:0] prefix
);

    localparam int LG = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] lvl [0:LG];

    always_comb
    begin
        lvl[0] = bits;
        for (int l = 0; l < LG; l++)
        begin
            for (int k = 0; k < WIDTH; k++)
            begin
                if (k >= (1 << l))
                begin
                    lvl[l+1][k] = lvl[l][k] | lvl[l][k - (1 << l)];
                end
                else
                begin
                    lvl[l+1][k] = lvl[l][k];
                end
            end
        end
    end

    assign prefix = lvl[LG];

endmodule

### rtl/spee_cell.sv
// One stack slot: holds a key, compares it, and loads from a neighbor or a bus.
// Depends on spee_pkg.
module spee_cell (
    input  logic                                clk,
    input  spee_pkg::cell_ctrl_t                ctrl,
    input  spee_pkg::cell_flags_t               flags,
    input  logic signed [spee_pkg::KEY_W-1:0]   key,
    input  logic signed [spee_pkg::KEY_W-1:0]   val_a,
    input  logic signed [spee_pkg::KEY_W-1:0]   val_b,
    input  logic signed [spee_pkg::KEY_W-1:0]   above,
    input  logic signed [spee_pkg::KEY_W-1:0]   below,
    output logic signed [spee_pkg::KEY_W-1:0]   data,
    output logic                                hit
);

    logic signed [spee_pkg::KEY_W-1:0] data_reg;
    logic signed [spee_pkg::KEY_W-1:0] data_next;
    logic                              hit_reg;
    logic                              hit_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            spee_pkg::CELL_INSERT:
            begin
                if (flags.sel_a)
                begin
                    data_next = key;
                end
                else if (flags.after_a)
                begin
                    data_next = above;
                end
            end
            spee_pkg::CELL_DELETE:
            begin
                if (flags.shift)
                begin
                    data_next = below;
                end
            end
            spee_pkg::CELL_SWAP:
            begin
                if (flags.sel_b)
                begin
                    data_next = val_a;
                end
                else if (flags.sel_a)
                begin
                    data_next = val_b;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    assign hit_next = ctrl.calc ? (flags.occ && (data_reg == key)) : hit_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

### rtl/stack_positional_edit_engine.sv
// A word is accepted, compared across the cell row in a compare cycle, then applied
// in an apply cycle that loads its result into the output slot. No new word is taken
// before that apply cycle; a stalled result holds it until the slot frees.
// Reset (rst_n low, async): fill count cleared, FSM idle, output slot empty.
// Cell contents are not reset; only slots below the fill count are ever read.
// Depends on spee_pkg, spee_cell and spee_prefix_or.
module stack_positional_edit_engine #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side, s_tdata from bit 0 up: func[2:0], key[34:3], pos_a[41:35],
    // pos_b[48:42], zero pad[55:49]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spee_pkg::S_TDATA_W-1:0]   s_tdata,
    // master side, m_tdata from bit 0 up: found[0], held[7:1], status[9:8],
    // zero pad[15:10]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [spee_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Fill count width and a compare width that holds both count+1 and a position.
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PW = ((CW > spee_pkg::POS_W) ? CW : spee_pkg::POS_W) + 1;

    localparam int KW = spee_pkg::KEY_W;

    // ---------------------------------------------------------------------
    // Control and operation registers
    // ---------------------------------------------------------------------
    spee_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [spee_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    spee_pkg::func_t            func_reg;
    logic signed [KW-1:0]       key_reg;
    logic [spee_pkg::POS_W-1:0] pos_a_reg;
    logic [spee_pkg::POS_W-1:0] pos_b_reg;
    logic signed [KW-1:0]       val_a_reg, val_a_next;
    logic signed [KW-1:0]       val_b_reg, val_b_next;

    logic accept;
    logic out_free;
    logic done;

    spee_pkg::cell_ctrl_t ctrl;

    // Result of the op in flight, valid during the apply cycle.
    logic              insert_ok;
    logic              swap_ok;
    logic              found;
    spee_pkg::status_t status;

    // ---------------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------------
    logic signed [KW-1:0]  cell_data [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] hit_vec;
    logic [STACK_DEPTH-1:0] hit_prefix;
    logic [STACK_DEPTH-1:0] sel_a_vec;
    logic [STACK_DEPTH-1:0] sel_a_prefix;
    logic [STACK_DEPTH-1:0] sel_b_vec;
    logic [STACK_DEPTH-1:0] occ_vec;

    logic [PW-1:0] pa_w;
    logic [PW-1:0] pb_w;
    logic [PW-1:0] cnt_w;

    assign pa_w  = PW'(pos_a_reg);
    assign pb_w  = PW'(pos_b_reg);
    assign cnt_w = PW'(count_reg);

    // Slot k (0 = top) is position k+1.
    always_comb
    begin
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            sel_a_vec[k] = (pa_w == PW'(k + 1));
            sel_b_vec[k] = (pb_w == PW'(k + 1));
            occ_vec[k]   = (PW'(k) < cnt_w);
        end
    end

    spee_prefix_or #(.WIDTH(STACK_DEPTH)) u_hit_prefix (
        .bits   (hit_vec),
        .prefix (hit_prefix)
    );

    spee_prefix_or #(.WIDTH(STACK_DEPTH)) u_sel_prefix (
        .bits   (sel_a_vec),
        .prefix (sel_a_prefix)
    );

    // Swap read bus: one-hot pick of the two slots, captured in the compare cycle.
    always_comb
    begin
        val_a_next = val_a_reg;
        val_b_next = val_b_reg;
        if (state_reg == spee_pkg::S_CALC)
        begin
            val_a_next = '0;
            val_b_next = '0;
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                val_a_next = val_a_next | (cell_data[k] & {KW{sel_a_vec[k]}});
                val_b_next = val_b_next | (cell_data[k] & {KW{sel_b_vec[k]}});
            end
        end
    end

    for (genvar k = 0; k < STACK_DEPTH; k++)
    begin : g_cell
        spee_pkg::cell_flags_t flags;
        logic signed [KW-1:0]  above;
        logic signed [KW-1:0]  below;

        assign flags.occ     = occ_vec[k];
        assign flags.sel_a   = sel_a_vec[k];
        assign flags.after_a = sel_a_prefix[k] & ~sel_a_vec[k];
        assign flags.sel_b   = sel_b_vec[k];
        assign flags.shift   = hit_prefix[k];

        if (k == 0)
        begin : g_top
            assign above = cell_data[k];
        end
        else
        begin : g_mid_up
            assign above = cell_data[k-1];
        end

        if (k == STACK_DEPTH - 1)
        begin : g_bottom
            assign below = cell_data[k];
        end
        else
        begin : g_mid_down
            assign below = cell_data[k+1];
        end

        spee_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .flags (flags),
            .key   (key_reg),
            .val_a (val_a_reg),
            .val_b (val_b_reg),
            .above (above),
            .below (below),
            .data  (cell_data[k]),
            .hit   (hit_vec[k])
        );
    end

    // ---------------------------------------------------------------------
    // Checks and result of the op in flight
    // ---------------------------------------------------------------------
    always_comb
    begin
        insert_ok  = 1'b0;
        swap_ok    = 1'b0;
        found      = 1'b0;
        status     = spee_pkg::ST_OK;
        count_next = count_reg;
        case (func_reg)
            spee_pkg::FN_INSERT:
            begin
                if (count_reg >= CW'(STACK_DEPTH))
                begin
                    status = spee_pkg::ST_FULL;
                end
                else if ((pa_w == '0) || (pa_w > (cnt_w + PW'(1))))
                begin
                    status = spee_pkg::ST_RANGE;
                end
                else
                begin
                    insert_ok  = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            spee_pkg::FN_DELETE:
            begin
                found = hit_prefix[STACK_DEPTH-1];
                if (found)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            spee_pkg::FN_SWAP:
            begin
                if ((pa_w == '0) || (pb_w == '0) || (pa_w > cnt_w) || (pb_w > cnt_w))
                begin
                    status = spee_pkg::ST_RANGE;
                end
                else
                begin
                    swap_ok = 1'b1;
                end
            end
            spee_pkg::FN_SEARCH:
            begin
                found = hit_prefix[STACK_DEPTH-1];
            end
            default:
            begin
                status = spee_pkg::ST_OK;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: IDLE -> CALC (compare) -> APPLY (update row, load result)
    // ---------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spee_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = spee_pkg::S_CALC;
                end
            end
            spee_pkg::S_CALC:
            begin
                state_next = spee_pkg::S_APPLY;
            end
            spee_pkg::S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = s_tvalid ? spee_pkg::S_CALC : spee_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spee_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        done      = 1'b0;
        ctrl.calc = 1'b0;
        ctrl.op   = spee_pkg::CELL_HOLD;
        case (state_reg)
            spee_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            spee_pkg::S_CALC:
            begin
                ctrl.calc = 1'b1;
            end
            spee_pkg::S_APPLY:
            begin
                done     = out_free;
                s_tready = out_free;
                if (out_free)
                begin
                    if (insert_ok)
                    begin
                        ctrl.op = spee_pkg::CELL_INSERT;
                    end
                    else if (func_reg == spee_pkg::FN_DELETE)
                    begin
                        ctrl.op = spee_pkg::CELL_DELETE;
                    end
                    else if (swap_ok)
                    begin
                        ctrl.op = spee_pkg::CELL_SWAP;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Output slot
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, status, spee_pkg::HELD_W'(count_next), found};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spee_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (done)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        val_a_reg   <= val_a_next;
        val_b_reg   <= val_b_next;
        if (accept)
        begin
            func_reg  <= spee_pkg::func_t'(s_tdata[2:0]);
            key_reg   <= s_tdata[34:3];
            pos_a_reg <= s_tdata[41:35];
            pos_b_reg <= s_tdata[48:42];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/spee_checker.sv
// Port-level checks for stack_positional_edit_engine, attached by bind.
// Depends on spee_pkg and the top level's port list.
module spee_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [spee_pkg::M_TDATA_W-1:0] m_tdata
);

    // Status is one of the three defined codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[9:8] == spee_pkg::ST_OK) ||
                     (m_tdata[9:8] == spee_pkg::ST_FULL) ||
                     (m_tdata[9:8] == spee_pkg::ST_RANGE))
        else $error("bad status code");

    // A match is only reported by ops that cannot fail.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[9:8] == spee_pkg::ST_OK))
        else $error("found with error status");

    // One word in flight: the compare cycle follows every accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accept during compare cycle");

    // Stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

endmodule

bind stack_positional_edit_engine spee_checker u_spee_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/testbench.sv
// Self-checking bench for stack_positional_edit_engine: directed edge cases, then
// random grow/fill/drain sequences. Bursty sender, patterned receiver stalls.
// Depends on spee_pkg and the RTL under rtl; reads nothing at run time.
module testbench;

    localparam int FUNC_W    = spee_pkg::FUNC_W;
    localparam int KEY_W     = spee_pkg::KEY_W;
    localparam int POS_W     = spee_pkg::POS_W;
    localparam int HELD_W    = spee_pkg::HELD_W;
    localparam int S_TDATA_W = spee_pkg::S_TDATA_W;
    localparam int M_TDATA_W = spee_pkg::M_TDATA_W;

    localparam int DEPTH       = 64;
    localparam int RANDOM_WORDS = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    // Func codes the block treats as no-ops.
    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_TOP = 7'd127;

    // Input word, func in the low bits as on s_tdata.
    typedef struct packed {
        logic [POS_W-1:0]  pos_b;
        logic [POS_W-1:0]  pos_a;
        logic [KEY_W-1:0]  key;
        logic [FUNC_W-1:0] func;
    } edit_word_t;

    // Result word, same layout as the low 10 bits of m_tdata.
    typedef struct packed {
        spee_pkg::status_t status;
        logic [HELD_W-1:0] held;
        logic              found;
    } edit_result_t;

    typedef struct packed {
        logic       hold_off;   // wait for all results before sending
        edit_word_t w;
    } pending_word_t;

    // Slot 0 is the bottom; top sits at fill - 1.
    typedef struct {
        logic [KEY_W-1:0] slots [DEPTH];
        int unsigned      fill;
    } stack_image_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    edit_word_t    drv_word = '0;
    pending_word_t stim_q[$];
    edit_result_t  result_q[$];
    stack_image_t  gen_img;     // tracks the stack while stimulus is built
    stack_image_t  live_img;    // tracks the stack as words are accepted
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            total_words = 0;
    int            checked_count = 0;

    assign s_tdata = S_TDATA_W'(drv_word);

    stack_positional_edit_engine #(.STACK_DEPTH(DEPTH)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // Applies one word to a stack image and returns what the block should report.
    // Insert: full check first, then position in 1..fill+1; top is position 1.
    // Delete: first match from the top, cells above it close the gap.
    // Swap: both positions in 1..fill, equal positions leave the stack alone.
    function automatic edit_result_t apply_edit(ref stack_image_t img,
                                                input edit_word_t w);
        edit_result_t     r;
        int unsigned      at, i, j, ia, ib;
        logic [KEY_W-1:0] t;
        bit               hit;
        r.found  = 1'b0;
        r.status = spee_pkg::ST_OK;
        hit      = 1'b0;
        case (w.func)
            spee_pkg::FN_INSERT:
            begin
                if (img.fill >= DEPTH)
                    r.status = spee_pkg::ST_FULL;
                else if (w.pos_a == 0 || w.pos_a > img.fill + 1)
                    r.status = spee_pkg::ST_RANGE;
                else
                begin
                    at = img.fill + 1 - w.pos_a;
                    for (i = img.fill; i > at; i--)
                        img.slots[i] = img.slots[i-1];
                    img.slots[at] = w.key;
                    img.fill++;
                end
            end
            spee_pkg::FN_DELETE:
            begin
                for (i = img.fill; i > 0 && !hit; i--)
                begin
                    if (img.slots[i-1] == w.key)
                    begin
                        hit = 1'b1;
                        for (j = i - 1; j + 1 < img.fill; j++)
                            img.slots[j] = img.slots[j+1];
                        img.fill--;
                    end
                end
                r.found = hit;
            end
            spee_pkg::FN_SWAP:
            begin
                if (w.pos_a == 0 || w.pos_b == 0 || w.pos_a > img.fill ||
                    w.pos_b > img.fill)
                    r.status = spee_pkg::ST_RANGE;
                else
                begin
                    ia = img.fill - w.pos_a;
                    ib = img.fill - w.pos_b;
                    t  = img.slots[ia];
                    img.slots[ia] = img.slots[ib];
                    img.slots[ib] = t;
                end
            end
            spee_pkg::FN_SEARCH:
            begin
                for (i = 0; i < img.fill; i++)
                    if (img.slots[i] == w.key) hit = 1'b1;
                r.found = hit;
            end
            default: ;
        endcase
        r.held = img.fill[HELD_W-1:0];
        return r;
    endfunction

    task automatic queue_edit(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                              input logic [POS_W-1:0] pa, input logic [POS_W-1:0] pb,
                              input bit hold_off);
        pending_word_t p;
        p.hold_off = hold_off;
        p.w.func   = func;
        p.w.key    = key;
        p.w.pos_a  = pa;
        p.w.pos_b  = pb;
        stim_q.push_back(p);
        void'(apply_edit(gen_img, p.w));
    endtask

    // Mostly keys already on the stack or from a small pool, so deletes and
    // searches hit and duplicates pile up.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4 && gen_img.fill > 0)
            return gen_img.slots[$urandom_range(0, gen_img.fill - 1)];
        if (roll < 7)
        begin
            case ($urandom_range(0, 5))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '1;
                default: return KEY_W'($urandom_range(0, 7));
            endcase
        end
        return $urandom;
    endfunction

    // Position inside 1..limit most of the time, otherwise anything 0..127.
    function automatic logic [POS_W-1:0] pick_pos(input int unsigned limit);
        if (limit > 0 && $urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(1, limit));
        return POS_W'($urandom_range(0, 127));
    endfunction

    task automatic build_random();
        bit          grow;
        int          roll, full_dwell;
        logic [POS_W-1:0] pa;
        grow       = 1'b1;
        full_dwell = 0;
        repeat (RANDOM_WORDS)
        begin
            roll = $urandom_range(0, 99);
            if (grow ? roll < 55 : roll < 10)
                queue_edit(spee_pkg::FN_INSERT, pick_key(),
                           pick_pos(gen_img.fill < DEPTH ? gen_img.fill + 1 : 0),
                           POS_W'($urandom), $urandom_range(0, 149) == 0);
            else if (grow ? roll < 65 : roll < 60)
                queue_edit(spee_pkg::FN_DELETE, pick_key(), POS_W'($urandom),
                           POS_W'($urandom), $urandom_range(0, 149) == 0);
            else if (roll < 78)
            begin
                pa = pick_pos(gen_img.fill);
                queue_edit(spee_pkg::FN_SWAP, $urandom, pa,
                           $urandom_range(0, 4) == 0 ? pa : pick_pos(gen_img.fill),
                           $urandom_range(0, 149) == 0);
            end
            else if (roll < 90)
                queue_edit(spee_pkg::FN_SEARCH, pick_key(), POS_W'($urandom),
                           POS_W'($urandom), $urandom_range(0, 149) == 0);
            else if (roll < 96)
                queue_edit(spee_pkg::FN_COUNT, $urandom, POS_W'($urandom),
                           POS_W'($urandom), $urandom_range(0, 149) == 0);
            else
                queue_edit(($urandom_range(0, 2) == 0) ? FN_SPARE_A :
                           (($urandom_range(0, 1) == 0) ? FN_SPARE_B : FN_SPARE_C),
                           $urandom, POS_W'($urandom), POS_W'($urandom), 1'b0);
            // grow to full, linger there a while, then drain to empty
            if (gen_img.fill == DEPTH) full_dwell++;
            if (full_dwell >= 12)
            begin
                grow       = 1'b0;
                full_dwell = 0;
            end
            if (gen_img.fill == 0) grow = 1'b1;
        end
    endtask

    initial
    begin : stimulus
        gen_img.fill  = 0;
        live_img.fill = 0;
        // empty stack
        queue_edit(spee_pkg::FN_COUNT,  '0, '0, '0, 1'b0);
        queue_edit(spee_pkg::FN_SEARCH, '0, '0, '0, 1'b0);
        queue_edit(spee_pkg::FN_DELETE, '0, '0, '0, 1'b0);          // no match
        queue_edit(spee_pkg::FN_SWAP,   '0, 7'd1, 7'd1, 1'b0);      // beyond count
        queue_edit(spee_pkg::FN_INSERT, 32'd1, 7'd0, '0, 1'b0);     // position zero
        queue_edit(spee_pkg::FN_INSERT, 32'd1, 7'd2, '0, 1'b0);     // beyond count+1
        // build MAX, -1, MIN, 0 from the top
        queue_edit(spee_pkg::FN_INSERT, KEY_MIN, 7'd1, '0, 1'b0);
        queue_edit(spee_pkg::FN_INSERT, KEY_MAX, 7'd1, '0, 1'b0);
        queue_edit(spee_pkg::FN_INSERT, '0, 7'd3, '0, 1'b0);        // at the bottom
        queue_edit(spee_pkg::FN_INSERT, '1, 7'd2, '0, 1'b0);        // in the middle
        queue_edit(spee_pkg::FN_INSERT, 32'd5, POS_TOP, '0, 1'b0);
        queue_edit(spee_pkg::FN_SWAP, '0, 7'd1, 7'd4, 1'b0);
        queue_edit(spee_pkg::FN_SWAP, '0, 7'd2, 7'd2, 1'b0);        // same position
        queue_edit(spee_pkg::FN_SWAP, '0, 7'd0, 7'd1, 1'b0);
        queue_edit(spee_pkg::FN_SWAP, '0, 7'd1, 7'd5, 1'b0);
        queue_edit(spee_pkg::FN_SWAP, '1, POS_TOP, POS_TOP, 1'b0);
        queue_edit(spee_pkg::FN_SEARCH, KEY_MIN, '0, '0, 1'b0);
        queue_edit(spee_pkg::FN_SEARCH, 32'd12345, '0, '0, 1'b0);
        queue_edit(spee_pkg::FN_INSERT, '1, 7'd1, '0, 1'b0);        // duplicate on top
        queue_edit(spee_pkg::FN_DELETE, '1, '0, '0, 1'b0);          // takes the top copy
        queue_edit(spee_pkg::FN_DELETE, 32'd7, '0, '0, 1'b0);
        queue_edit(spee_pkg::FN_COUNT, '1, POS_TOP, POS_TOP, 1'b0);
        queue_edit(FN_SPARE_A, '1, POS_TOP, POS_TOP, 1'b0);
        queue_edit(FN_SPARE_B, '0, '0, '0, 1'b0);
        queue_edit(FN_SPARE_C, '1, POS_TOP, POS_TOP, 1'b0);
        // random part opens behind a full drain
        queue_edit(spee_pkg::FN_COUNT, '0, '0, '0, 1'b1);
        build_random();
        total_words = stim_q.size();

        wait (rst_n);
        // every queued word must come back as a checked result
        while (checked_count < total_words)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && result_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Sender: bursts of words with gaps between; a marked word waits until the
    // result store is empty.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_words
        edit_result_t  r;
        pending_word_t p;
        logic          next_valid;
        edit_word_t    next_word;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            drv_word   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            next_valid = s_tvalid;
            next_word  = drv_word;
            if (s_tvalid && s_tready)
            begin
                r = apply_edit(live_img, drv_word);
                result_q.push_back(r);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (stim_q.size() != 0 &&
                         !(stim_q[0].hold_off && result_q.size() != 0))
                begin
                    p          = stim_q.pop_front();
                    next_word  = p.w;
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            s_tvalid <= next_valid;
            drv_word <= next_word;
        end
    end

    // Receiver: checks each word, and picks a new stall pattern each time rx_phase ends its
    // window: always ready, random stalls, or ready on a fixed pattern of rx_phase values.
    int rx_mode  = 0;
    int rx_phase = 0;

    always @(posedge clk or negedge rst_n)
    begin : check_results
        edit_result_t want;
        edit_result_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_mode  <= 0;
            rx_phase <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                checked_count++;
                got = edit_result_t'(m_tdata[9:0]);
                if (result_q.size() == 0)
                begin
                    $display("%0t: result word with none pending, m_tdata=%h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, got.found);
                        mismatch_count++;
                    end
                    if (got.held !== want.held)
                    begin
                        $display("%0t: held expected %0d actual %0d",
                                 $time, want.held, got.held);
                        mismatch_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatch_count++;
                    end
                end
            end
            rx_phase <= rx_phase + 1;
            if (rx_phase % 64 == 63)
                rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 2) != 0;
                default: m_tready <= (rx_phase % 5) == 0;
            endcase
        end
    end

endmodule

### filelist.f
rtl/spee_pkg.sv
rtl/spee_prefix_or.sv
rtl/spee_cell.sv
rtl/stack_positional_edit_engine.sv
rtl/spee_checker.sv
bench/testbench.sv
